[rtl/phs_pkg.sv]
// Shared types and constants for the packet header statistics unit.
package phs_pkg;

  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthArp  = 16'h0806;
  localparam logic [47:0] MacOnes = 48'hFFFF_FFFF_FFFF;
  localparam int          TtlBins = 256;

  typedef enum logic [1:0] {
    KindOther,
    KindIpv4,
    KindArp
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] ethertype;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  hop_limit;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } word_t;

  typedef enum logic [3:0] {
    StIdle,
    StType,
    StTypeUpd,
    StSrc,
    StSrcUpd,
    StDst,
    StDstUpd,
    StTtl,
    StTtlUpd,
    StSnd,
    StTgt,
    StDone
  } state_e;

endpackage

[rtl/phs_front.sv]
// Front end: accepts a header, classifies it and holds it in a two-entry queue.
module phs_front import phs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] ethertype_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [7:0]  hop_limit_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [47:0] target_mac_i,
  input  logic [31:0] target_ip_i,
  output logic        q_valid_o,
  output word_t       q_word_o,
  input  logic        q_pop_i
);

  word_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  word_t      w;
  logic       push;

  assign busy_o    = cnt_q == 2'd2;
  assign push      = start_i && !busy_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_word_o  = mem_q[rp_q];

  always_comb begin
    w.ethertype  = ethertype_i;
    w.src_ip     = src_ip_i;
    w.dst_ip     = dst_ip_i;
    w.hop_limit  = hop_limit_i;
    w.sender_mac = sender_mac_i;
    w.sender_ip  = sender_ip_i;
    w.target_mac = target_mac_i;
    w.target_ip  = target_ip_i;
    if (ethertype_i == EthIpv4) w.kind = KindIpv4;
    else if (ethertype_i == EthArp) w.kind = KindArp;
    else w.kind = KindOther;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

[rtl/phs_back.sv]
// Back end: walks the keyed tables one entry a cycle and updates counters.
module phs_back import phs_pkg::*; #(
  parameter int TYPE_DEPTH  = 16,
  parameter int ADDR_DEPTH  = 64,
  parameter int PAIR_DEPTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  word_t       q_word_i,
  output logic        q_pop_o,
  output logic        done_o,
  output logic [31:0] ethertype_count_o,
  output logic [31:0] source_count_o,
  output logic [31:0] dest_count_o,
  output logic [31:0] ttl_count_o,
  output logic        sender_pair_new_o,
  output logic        target_pair_new_o,
  output logic        table_full_o,
  output logic [31:0] frame_total_o,
  output logic [31:0] ip_total_o
);

  localparam int TW  = TYPE_DEPTH > 1 ? $clog2(TYPE_DEPTH) : 1;
  localparam int AW  = ADDR_DEPTH > 1 ? $clog2(ADDR_DEPTH) : 1;
  localparam int PW  = PAIR_DEPTH > 1 ? $clog2(PAIR_DEPTH) : 1;
  localparam int TIW = $clog2(TYPE_DEPTH + 1);
  localparam int AIW = $clog2(ADDR_DEPTH + 1);
  localparam int PIW = $clog2(PAIR_DEPTH + 1);
  localparam int TAW = TIW > AIW ? TIW : AIW;
  localparam int IW  = TAW > PIW ? TAW : PIW;
  localparam logic [COUNT_WIDTH-1:0] CMax = '1;
  localparam logic [IW-1:0] TDep = IW'(TYPE_DEPTH);
  localparam logic [IW-1:0] ADep = IW'(ADDR_DEPTH);
  localparam logic [IW-1:0] PDep = IW'(PAIR_DEPTH);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  logic [15:0] tkey [TYPE_DEPTH];
  cnt_t        tcnt [TYPE_DEPTH];
  logic [31:0] skey [ADDR_DEPTH];
  cnt_t        scnt [ADDR_DEPTH];
  logic [31:0] dkey [ADDR_DEPTH];
  cnt_t        dcnt [ADDR_DEPTH];
  cnt_t        ttl_mem [TtlBins];
  logic [79:0] pmem [PAIR_DEPTH];

  state_e state_q, state_d;
  word_t  w_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] tused_q, sused_q, dused_q, pused_q;
  logic [8:0]    clr_q;
  cnt_t   frames_q, ip_q, rd_q;
  cnt_t   tc_q, sc_q;
  logic   snew_q, tnew_q, full_q, sdup_q;

  // registered memory reads at the scan index
  logic [15:0] tk_q;
  logic [31:0] ak_q;
  logic [79:0] pk_q;
  logic        rd_ok_q;

  function automatic cnt_t sat(cnt_t v);
    return (v == CMax) ? v : v + cnt_t'(1);
  endfunction

  logic [79:0] spair, tpair;
  assign spair = {w_q.sender_mac, w_q.sender_ip};
  assign tpair = {w_q.target_mac, w_q.target_ip};

  logic clearing;
  assign clearing = !clr_q[8];

  // scan: idx_q is issued, next cycle data arrives; we check data of idx_q-1
  logic [IW-1:0] used_sel;
  always_comb begin
    unique case (state_q)
      StType:  used_sel = tused_q;
      StSrc:   used_sel = sused_q;
      StDst:   used_sel = dused_q;
      default: used_sel = pused_q;
    endcase
  end

  logic [IW-1:0] hit_idx_q;
  logic          hit;
  always_comb begin
    hit = 1'b0;
    unique case (state_q)
      StType:  hit = rd_ok_q && tk_q == w_q.ethertype;
      StSrc:   hit = rd_ok_q && ak_q == w_q.src_ip;
      StDst:   hit = rd_ok_q && ak_q == w_q.dst_ip;
      StSnd:   hit = rd_ok_q && pk_q == spair;
      StTgt:   hit = rd_ok_q && pk_q == tpair;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tk_q <= tkey[idx_q[TW-1:0]];
    tc_q <= tcnt[idx_q[TW-1:0]];
    if (state_q == StSrc || state_q == StSrcUpd) begin
      ak_q <= skey[idx_q[AW-1:0]];
      sc_q <= scnt[idx_q[AW-1:0]];
    end else begin
      ak_q <= dkey[idx_q[AW-1:0]];
      sc_q <= dcnt[idx_q[AW-1:0]];
    end
    pk_q <= pmem[idx_q[PW-1:0]];
    rd_q <= ttl_mem[w_q.hop_limit];
  end

  logic scan, tend;
  assign scan = state_q == StType || state_q == StSrc || state_q == StDst ||
                state_q == StSnd || state_q == StTgt;
  // scan exhausted once the last used entry has been compared
  assign tend = !hit && !(idx_q < used_sel);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      StIdle: if (q_valid_i && !clearing) begin
        q_pop_o = 1'b1;
        state_d = StType;
        idx_d   = '0;
      end
      StType:  if (hit || tend) state_d = StTypeUpd; else idx_d = idx_q + 1'b1;
      StTypeUpd: begin
        idx_d = '0;
        if (w_q.kind == KindIpv4) state_d = StSrc;
        else if (w_q.kind == KindArp) state_d = StSnd;
        else state_d = StDone;
      end
      StSrc:    if (hit || tend) state_d = StSrcUpd; else idx_d = idx_q + 1'b1;
      StSrcUpd: begin state_d = StDst; idx_d = '0; end
      StDst:    if (hit || tend) state_d = StDstUpd; else idx_d = idx_q + 1'b1;
      StDstUpd: state_d = StTtl;
      StTtl:    state_d = StTtlUpd;
      StTtlUpd: state_d = StDone;
      StSnd: if (hit || tend) begin state_d = StTgt; idx_d = '0; end
             else idx_d = idx_q + 1'b1;
      StTgt:  if (hit || tend) state_d = StDone; else idx_d = idx_q + 1'b1;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic snd_res;
  assign snd_res = w_q.sender_mac == '0 || w_q.sender_mac == MacOnes;
  logic tgt_res;
  assign tgt_res = w_q.target_mac == '0 || w_q.target_mac == MacOnes;

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_pop_o) w_q <= q_word_i;
    if (clearing) ttl_mem[clr_q[7:0]] <= '0;
    else if (state_q == StTtlUpd) ttl_mem[w_q.hop_limit] <= sat(rd_q);
    if (state_q == StType && (hit || tend)) begin
      if (hit) begin
        tcnt[hit_idx_q[TW-1:0]] <= sat(tc_q);
      end else if (tused_q < TDep) begin
        tkey[tused_q[TW-1:0]] <= w_q.ethertype;
        tcnt[tused_q[TW-1:0]] <= cnt_t'(1);
      end
    end
    if (state_q == StSrc && (hit || tend)) begin
      if (hit) scnt[hit_idx_q[AW-1:0]] <= sat(sc_q);
      else if (sused_q < ADep) begin
        skey[sused_q[AW-1:0]] <= w_q.src_ip;
        scnt[sused_q[AW-1:0]] <= cnt_t'(1);
      end
    end
    if (state_q == StDst && (hit || tend)) begin
      if (hit) dcnt[hit_idx_q[AW-1:0]] <= sat(sc_q);
      else if (dused_q < ADep) begin
        dkey[dused_q[AW-1:0]] <= w_q.dst_ip;
        dcnt[dused_q[AW-1:0]] <= cnt_t'(1);
      end
    end
    if (state_q == StSnd && tend && !snd_res && pused_q < PDep)
      pmem[pused_q[PW-1:0]] <= spair;
    if (state_q == StTgt && tend && !tgt_res && pused_q < PDep && !sdup_q)
      pmem[pused_q[PW-1:0]] <= tpair;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idx_q     <= '0;
      hit_idx_q <= '0;
      rd_ok_q   <= 1'b0;
      tused_q   <= '0;
      sused_q   <= '0;
      dused_q   <= '0;
      pused_q   <= '0;
      clr_q     <= '0;
      frames_q  <= '0;
      ip_q      <= '0;
      ethertype_count_o <= '0;
      source_count_o    <= '0;
      dest_count_o      <= '0;
      ttl_count_o       <= '0;
      sender_pair_new_o <= 1'b0;
      target_pair_new_o <= 1'b0;
      full_q    <= 1'b0;
      snew_q    <= 1'b0;
      tnew_q    <= 1'b0;
      sdup_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      hit_idx_q <= idx_q;
      // drops to zero whenever the state moves on
      rd_ok_q   <= scan && state_d == state_q && idx_q < used_sel;
      if (clearing) clr_q <= clr_q + 9'd1;
      unique case (state_q)
        StIdle: if (q_pop_o) begin
          full_q            <= 1'b0;
          snew_q            <= 1'b0;
          tnew_q            <= 1'b0;
          sdup_q            <= 1'b0;
          ethertype_count_o <= '0;
          source_count_o    <= '0;
          dest_count_o      <= '0;
          ttl_count_o       <= '0;
          frames_q          <= sat(frames_q);
        end
        StType: if (hit || tend) begin
          if (hit) ethertype_count_o <= 32'(sat(tc_q));
          else if (tused_q < TDep) begin
            ethertype_count_o <= 32'd1;
            tused_q <= tused_q + 1'b1;
          end else full_q <= 1'b1;
        end
        StTypeUpd: if (w_q.kind == KindIpv4) ip_q <= sat(ip_q);
        StSrc: if (hit || tend) begin
          if (hit) source_count_o <= 32'(sat(sc_q));
          else if (sused_q < ADep) begin
            source_count_o <= 32'd1;
            sused_q <= sused_q + 1'b1;
          end else full_q <= 1'b1;
        end
        StDst: if (hit || tend) begin
          if (hit) dest_count_o <= 32'(sat(sc_q));
          else if (dused_q < ADep) begin
            dest_count_o <= 32'd1;
            dused_q <= dused_q + 1'b1;
          end else full_q <= 1'b1;
        end
        StTtlUpd: ttl_count_o <= 32'(sat(rd_q));
        StSnd: if (hit || tend) begin
          if (!hit && !snd_res) begin
            if (pused_q < PDep) begin
              snew_q  <= 1'b1;
              pused_q <= pused_q + 1'b1;
              sdup_q  <= spair == tpair;
            end else full_q <= 1'b1;
          end
        end
        StTgt: if (hit || tend) begin
          if (!hit && !tgt_res && !sdup_q) begin
            if (pused_q < PDep) begin
              tnew_q  <= 1'b1;
              pused_q <= pused_q + 1'b1;
            end else full_q <= 1'b1;
          end
        end
        default: ;
      endcase
      if (state_q == StDone) begin
        sender_pair_new_o <= snew_q;
        target_pair_new_o <= tnew_q;
      end
    end
  end

  assign done_o        = state_q == StDone;
  assign table_full_o  = full_q;
  assign frame_total_o = 32'(frames_q);
  assign ip_total_o    = 32'(ip_q);

endmodule

[rtl/packet_header_statistics_unit.sv]
// Top level of the packet header statistics unit.
// One header word is taken when start_i is high and busy_o is low; a two-word
// queue lets the next headers in while the back end scans. The back end pops a
// word and then walks each table one entry a cycle; a table scan compares all
// used entries on a miss. A word of another ethertype scans one table, and an
// IPv4 or an ARP word scans three. After reset the TTL histogram, all 256 bins,
// is cleared before the first word is processed. done_o is high for one cycle,
// registered from the back end's done state, and every result port is valid
// in that cycle; the receiver cannot stall and must take the result then.
module packet_header_statistics_unit import phs_pkg::*; #(
  parameter int TYPE_DEPTH  = 16,
  parameter int ADDR_DEPTH  = 64,
  parameter int PAIR_DEPTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] ethertype_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [7:0]  hop_limit_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [47:0] target_mac_i,
  input  logic [31:0] target_ip_i,
  output logic        done_o,
  output logic [31:0] ethertype_count_o,
  output logic [31:0] source_count_o,
  output logic [31:0] dest_count_o,
  output logic [31:0] ttl_count_o,
  output logic        sender_pair_new_o,
  output logic        target_pair_new_o,
  output logic        table_full_o,
  output logic [31:0] frame_total_o,
  output logic [31:0] ip_total_o
);

  word_t qw;
  logic  qv, qpop, dn, dn_q;

  phs_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .ethertype_i, .src_ip_i, .dst_ip_i, .hop_limit_i,
    .sender_mac_i, .sender_ip_i, .target_mac_i, .target_ip_i,
    .q_valid_o(qv), .q_word_o(qw), .q_pop_i(qpop)
  );

  phs_back #(
    .TYPE_DEPTH(TYPE_DEPTH), .ADDR_DEPTH(ADDR_DEPTH),
    .PAIR_DEPTH(PAIR_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_word_i(qw), .q_pop_o(qpop), .done_o(dn),
    .ethertype_count_o, .source_count_o, .dest_count_o, .ttl_count_o,
    .sender_pair_new_o, .target_pair_new_o, .table_full_o,
    .frame_total_o, .ip_total_o
  );

  // strobe registered from the back end's done state, when all result ports settle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dn_q <= 1'b0;
    else dn_q <= dn;
  end
  assign done_o = dn_q;

endmodule

[test/tb.sv]
// Testbench for the packet header statistics unit: directed table plus random headers.
module tb;
  import phs_pkg::*;

  typedef struct {
    logic [15:0] etype;
    logic [31:0] src, dst;
    logic [7:0]  ttl;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [47:0] tmac;
    logic [31:0] tip;
  } hdr_t;

  typedef struct {
    logic [31:0] ec, sc, dc, tc;
    logic        sn, tn, fl;
    logic [31:0] ft, it;
  } stats_t;

  typedef struct {
    hdr_t   h;
    bit     typed;
    stats_t want;
  } row_t;

  localparam int TypeIdx = 0, SrcIdx = 1, DstIdx = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o, done_o;
  logic [15:0] ethertype_i = '0;
  logic [31:0] src_ip_i = '0, dst_ip_i = '0, sender_ip_i = '0, target_ip_i = '0;
  logic [7:0]  hop_limit_i = '0;
  logic [47:0] sender_mac_i = '0, target_mac_i = '0;
  logic [31:0] ethertype_count_o, source_count_o, dest_count_o, ttl_count_o;
  logic        sender_pair_new_o, target_pair_new_o, table_full_o;
  logic [31:0] frame_total_o, ip_total_o;

  packet_header_statistics_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracked copy of the block's tables
  logic [31:0] key_tab [3][64];
  logic [31:0] cnt_tab [3][64];
  int          key_used [3];
  int          key_depth [3] = '{16, 64, 64};
  logic [31:0] ttl_hist [256];
  logic [47:0] pair_mac [32];
  logic [31:0] pair_ip [32];
  int          pair_used;
  logic [31:0] frames_cnt, ip_cnt;

  stats_t stats_q[$];
  int     errors = 0;
  int     accepted = 0, checked = 0, drops = 0, new_pairs = 0;

  logic [31:0] addr_pool [80];
  logic [47:0] mac_pool [40];
  logic [15:0] type_pool [24];

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic logic [31:0] tally(int t, logic [31:0] key, inout logic full);
    for (int i = 0; i < key_used[t]; i++)
      if (key_tab[t][i] == key) begin
        cnt_tab[t][i] = sat_inc(cnt_tab[t][i]);
        return cnt_tab[t][i];
      end
    if (key_used[t] < key_depth[t]) begin
      key_tab[t][key_used[t]] = key;
      cnt_tab[t][key_used[t]] = 1;
      key_used[t]++;
      return 1;
    end
    full = 1'b1;
    return 0;
  endfunction

  function automatic logic note_pair(logic [47:0] mac, logic [31:0] ip, inout logic full);
    for (int i = 0; i < pair_used; i++)
      if (pair_mac[i] == mac && pair_ip[i] == ip) return 1'b0;
    if (mac == '0 || mac == MacOnes) return 1'b0;
    if (pair_used < 32) begin
      pair_mac[pair_used] = mac;
      pair_ip[pair_used] = ip;
      pair_used++;
      return 1'b1;
    end
    full = 1'b1;
    return 1'b0;
  endfunction

  function automatic stats_t update_stats(hdr_t h);
    stats_t s;
    logic full;
    full = 1'b0;
    s = '{default: '0};
    frames_cnt = sat_inc(frames_cnt);
    s.ec = tally(TypeIdx, {16'h0, h.etype}, full);
    if (h.etype == EthIpv4) begin
      ip_cnt = sat_inc(ip_cnt);
      s.sc = tally(SrcIdx, h.src, full);
      s.dc = tally(DstIdx, h.dst, full);
      ttl_hist[h.ttl] = sat_inc(ttl_hist[h.ttl]);
      s.tc = ttl_hist[h.ttl];
    end
    if (h.etype == EthArp) begin
      s.sn = note_pair(h.smac, h.sip, full);
      s.tn = note_pair(h.tmac, h.tip, full);
    end
    s.fl = full;
    s.ft = frames_cnt;
    s.it = ip_cnt;
    return s;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h (word %0d)", what, got, want, checked);
    errors++;
  endtask

  // every result port is valid in the cycle done_o is high
  always @(posedge clk_i) begin
    stats_t w;
    if (done_o === 1'b1) begin
      if (stats_q.size() == 0) begin
        $display("unexpected result word %0d", checked);
        errors++;
      end else begin
        w = stats_q.pop_front();
        if (ethertype_count_o !== w.ec) report("ethertype_count", ethertype_count_o, w.ec);
        if (source_count_o !== w.sc) report("source_count", source_count_o, w.sc);
        if (dest_count_o !== w.dc) report("dest_count", dest_count_o, w.dc);
        if (ttl_count_o !== w.tc) report("ttl_count", ttl_count_o, w.tc);
        if (sender_pair_new_o !== w.sn)
          report("sender_pair_new", 32'(sender_pair_new_o), 32'(w.sn));
        if (target_pair_new_o !== w.tn)
          report("target_pair_new", 32'(target_pair_new_o), 32'(w.tn));
        if (table_full_o !== w.fl) report("table_full", 32'(table_full_o), 32'(w.fl));
        if (frame_total_o !== w.ft) report("frame_total", frame_total_o, w.ft);
        if (ip_total_o !== w.it) report("ip_total", ip_total_o, w.it);
        if (w.fl) drops++;
        if (w.sn || w.tn) new_pairs++;
      end
      checked++;
    end
  end

  task automatic send(hdr_t h, bit typed, stats_t want, int idle_pct);
    stats_t p;
    start_i      <= 1'b1;
    ethertype_i  <= h.etype;
    src_ip_i     <= h.src;
    dst_ip_i     <= h.dst;
    hop_limit_i  <= h.ttl;
    sender_mac_i <= h.smac;
    sender_ip_i  <= h.sip;
    target_mac_i <= h.tmac;
    target_ip_i  <= h.tip;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    p = update_stats(h);
    stats_q.push_back(typed ? want : p);
    accepted++;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 200)) @(posedge clk_i);
    end
  endtask

  function automatic hdr_t rand_hdr();
    hdr_t h;
    int k;
    k = $urandom_range(99);
    h.src  = ($urandom_range(9) < 7) ? addr_pool[$urandom_range(79)] : $urandom;
    h.dst  = ($urandom_range(9) < 7) ? addr_pool[$urandom_range(79)] : $urandom;
    h.ttl  = 8'($urandom);
    h.smac = mac_pool[$urandom_range(39)];
    h.tmac = mac_pool[$urandom_range(39)];
    h.sip  = addr_pool[$urandom_range(7)];
    h.tip  = ($urandom_range(3) == 0) ? $urandom : addr_pool[$urandom_range(7)];
    if ($urandom_range(9) == 0) h.smac = 48'({$urandom, $urandom});
    if ($urandom_range(19) == 0) h.tmac = h.smac;
    if ($urandom_range(19) == 0) h.tip = h.sip;
    if (k < 40)      h.etype = EthIpv4;
    else if (k < 75) h.etype = EthArp;
    else if (k < 92) h.etype = type_pool[$urandom_range(23)];
    else             h.etype = 16'($urandom);
    return h;
  endfunction

  row_t   plan[$];
  hdr_t   h;
  stats_t z;
  int     wait_cnt, idle_pct;

  function automatic stats_t st(logic [31:0] ec, sc, dc, tc, logic sn, tn, fl,
                                logic [31:0] ft, it);
    stats_t s;
    s = '{ec, sc, dc, tc, sn, tn, fl, ft, it};
    return s;
  endfunction

  function automatic hdr_t hd(logic [15:0] e, logic [31:0] s, d, logic [7:0] t,
                              logic [47:0] sm, logic [31:0] si, logic [47:0] tm,
                              logic [31:0] ti);
    hdr_t x;
    x = '{e, s, d, t, sm, si, tm, ti};
    return x;
  endfunction

  initial begin
    z = '{default: '0};
    key_used = '{0, 0, 0};
    pair_used = 0;
    frames_cnt = 0;
    ip_cnt = 0;
    for (int i = 0; i < 256; i++) ttl_hist[i] = 0;
    for (int i = 0; i < 80; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < 40; i++) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = '0;
    mac_pool[1] = MacOnes;
    for (int i = 0; i < 24; i++) type_pool[i] = 16'($urandom);

    plan.push_back('{hd(EthIpv4, 32'h0, '1, 8'h00, '0, '0, '0, '0), 1,
                     st(1, 1, 1, 1, 0, 0, 0, 1, 1)});
    plan.push_back('{hd(EthIpv4, '1, 32'h0, 8'hFF, '1, '1, '1, '1), 1,
                     st(2, 1, 1, 1, 0, 0, 0, 2, 2)});
    // reserved MACs on both sides: nothing stored, no drop
    plan.push_back('{hd(EthArp, '1, '1, 8'hFF, '0, '1, MacOnes, '0), 1,
                     st(1, 0, 0, 0, 0, 0, 0, 3, 2)});
    // sender and target the same pair: only the sender is new
    plan.push_back('{hd(EthArp, '0, '0, '0, 48'h1, 32'h5, 48'h1, 32'h5), 1,
                     st(2, 0, 0, 0, 1, 0, 0, 4, 2)});
    plan.push_back('{hd(16'h0000, '1, '1, '1, '1, '1, '1, '1), 1,
                     st(1, 0, 0, 0, 0, 0, 0, 5, 2)});
    plan.push_back('{hd(16'hFFFF, '0, '0, '0, '0, '0, '0, '0), 1,
                     st(1, 0, 0, 0, 0, 0, 0, 6, 2)});
    plan.push_back('{hd(EthIpv4, 32'h0, 32'h0, 8'h00, '0, '0, '0, '0), 0, z});
    plan.push_back('{hd(EthIpv4, '1, '1, 8'hFF, '0, '0, '0, '0), 0, z});
    plan.push_back('{hd(EthArp, '0, '0, '0, 48'hFFFF_FFFF_FFFE, '1, 48'h1, 32'h5), 0, z});
    plan.push_back('{hd(EthArp, '0, '0, '0, 48'h1, 32'h5, 48'h1, 32'h6), 0, z});
    plan.push_back('{hd(16'h0806 ^ 16'h0001, '0, '0, '0, 48'h2, '0, 48'h3, '0), 0, z});
    // fill the ethertype table past its depth
    for (int i = 0; i < 14; i++)
      plan.push_back('{hd(16'(16'h1000 + i), '0, '0, '0, '0, '0, '0, '0), 0, z});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send(plan[i].h, plan[i].typed, plan[i].want, 0);

    for (int n = 0; n < 1550; n++) begin
      case (n * 4 / 1550)
        0: idle_pct = 0;
        1: idle_pct = 76;
        2: idle_pct = 0;
        default: idle_pct = 16;
      endcase
      if (n == 700) begin
        start_i <= 1'b0;
        while (stats_q.size() != 0) @(posedge clk_i);
      end
      h = rand_hdr();
      send(h, 0, z, idle_pct);
    end
    start_i <= 1'b0;

    wait_cnt = 0;
    while (stats_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (300) @(posedge clk_i);
    if (stats_q.size() != 0) begin
      $display("%0d result words never arrived", stats_q.size());
      errors++;
    end
    $display("%0d headers sent, %0d results checked, %0d with dropped keys, %0d with new pairs",
             accepted, checked, drops, new_pairs);
    $display("tables used: %0d types, %0d sources, %0d destinations, %0d ARP pairs",
             key_used[TypeIdx], key_used[SrcIdx], key_used[DstIdx], pair_used);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
